[hdl/smvk_pkg.sv]
// ----------------------------------------------------------------------------
// smvk_pkg
// Shared constants, codes and saturation helper of the scaled matrix-vector
// operator.
// ----------------------------------------------------------------------------
package smvk_pkg;

  localparam int MAX_ROWS_DEF  = 32;
  localparam int MAX_COLS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] ACT_LOAD_MAT   = 3'd0;
  localparam logic [2:0] ACT_LOAD_SCALE = 3'd1;
  localparam logic [2:0] ACT_LOAD_X     = 3'd2;
  localparam logic [2:0] ACT_LOAD_V     = 3'd3;
  localparam logic [2:0] ACT_RUN        = 3'd4;

  localparam logic [2:0] OP_FWD = 3'd0;
  localparam logic [2:0] OP_ADJ = 3'd1;
  localparam logic [2:0] OP_G   = 3'd2;
  localparam logic [2:0] OP_NP  = 3'd3;
  localparam logic [2:0] OP_ND  = 3'd4;
  localparam logic [2:0] OP_RES = 3'd5;
  localparam logic [2:0] OP_DIV = 3'd6;
  localparam logic [2:0] OP_MUL = 3'd7;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic              clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = Q_MAX;
    end else if (v < -64'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = Q_MIN;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/smvk_ram.sv]
// ----------------------------------------------------------------------------
// smvk_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module smvk_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hdl/scaled_matvec_kkt_operator_core.sv]
// ----------------------------------------------------------------------------
// scaled_matvec_kkt_operator_core
// Load beats write one entry each in the accept cycle, one per cycle while not busy, no result.
// A run beat keeps busy high while one shared 32x32 multiplier walks the RAMs,
// reading, multiplying and accumulating each matrix product term, saturating each
// element, and dividing by bit-serial shift-subtract. Results strobe one per cycle
// at most; last is set as busy falls. Reset: scales read as one, sizes at maximum.
// ----------------------------------------------------------------------------
module scaled_matvec_kkt_operator_core
  import smvk_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action_i,
  input  logic [4:0]         row_i,
  input  logic [4:0]         col_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic [2:0]         op_i,
  output logic               out_valid_o,
  output logic [4:0]         out_index_o,
  output logic signed [31:0] out_value_o,
  output logic               out_part_o,
  output logic               saturated_o,
  output logic               divide_fault_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i
);

  localparam int VEC_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IW    = (VEC_N > 1) ? $clog2(VEC_N) : 1;
  localparam int LW    = $clog2(VEC_N + 1);
  localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MDEP  = MAX_ROWS * MAX_COLS;
  localparam int MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;
  localparam int TAW   = IW;
  localparam int NW    = 32 + FRAC_BITS;
  localparam int CW    = $clog2(NW + 1);
  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

  localparam logic [2:0] PH_SCALE = 3'd0;
  localparam logic [2:0] PH_FWD   = 3'd1;
  localparam logic [2:0] PH_ADJ   = 3'd2;
  localparam logic [2:0] PH_G     = 3'd3;
  localparam logic [2:0] PH_DIV   = 3'd4;
  localparam logic [2:0] PH_MUL   = 3'd5;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_SAT2 = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_DSET = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DFIN = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]  st_q, st_d;
  logic [1:0]  seq_q, seq_d;
  logic [2:0]  op_q, op_d;
  logic [IW-1:0] elem_q, elem_d, k_q, k_d;
  logic signed [63:0] acc_q, acc_d, prod_q, prod_d;
  logic signed [31:0] tv_q, tv_d, res_q, res_d;
  logic f_q, f_d, fault_q, fault_d, pf_q, pf_d, any_q, any_d;
  logic [NW-1:0] dn_q, dn_d;
  logic [31:0] drem_q, drem_d, dd_q, dd_d;
  logic dneg_q, dneg_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic [5:0] rows_q, cols_q;
  logic [MAX_COLS-1:0] xs_vld_q;
  logic xs_vld_r_q;

  logic ov_q, ov_d, opart_q, opart_d, osat_q, osat_d, ofault_q, ofault_d, olast_q, olast_d;
  logic [4:0] oidx_q, oidx_d;
  logic signed [31:0] oval_q, oval_d;

  logic [LW-1:0] eff_m, eff_n, olen, ilen;
  logic [2:0] ph;
  logic src_t, to_t, fin, part, extra, diff;
  logic acc_in, ld_mat, ld_sc, ld_x, ld_v;
  logic e_last, k_last;

  logic mat_we, xs_we, x_we, v_we, p_we, t_we;
  logic [MAW-1:0] mat_addr;
  logic [CAW-1:0] xs_addr, x_addr, p_addr;
  logic [RAW-1:0] v_addr;
  logic [TAW-1:0] t_addr;
  logic [31:0] mat_rd, x_rd, v_rd, p_rd;
  logic [63:0] xs_rd;
  logic [32:0] t_rd;
  logic signed [31:0] xq, sq, mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [32:0] dtry;
  logic signed [63:0] qmag, dvec;
  sat_t sat_a, sat_p, sat_d, sat_q;

  always_comb begin
    if (rows_q == 6'd0) begin
      eff_m = LW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      eff_m = LW'(MAX_ROWS);
    end else begin
      eff_m = LW'(rows_q);
    end
    if (cols_q == 6'd0) begin
      eff_n = LW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      eff_n = LW'(MAX_COLS);
    end else begin
      eff_n = LW'(cols_q);
    end
  end

  always_comb begin
    ph = PH_MUL; src_t = 1'b0; to_t = 1'b0; fin = 1'b0;
    part = 1'b0; extra = 1'b0; diff = 1'b0;
    case (op_q)
      OP_FWD: begin
        if (seq_q == 2'd0) begin
          ph = PH_SCALE;
        end else begin
          ph = PH_FWD; fin = 1'b1; part = 1'b1;
        end
      end
      OP_ADJ: begin
        ph = PH_ADJ; fin = 1'b1;
      end
      OP_G: begin
        ph = PH_G; fin = 1'b1;
      end
      OP_NP: begin
        case (seq_q)
          2'd0: ph = PH_SCALE;
          2'd1: begin
            ph = PH_FWD; to_t = 1'b1;
          end
          default: begin
            ph = PH_ADJ; src_t = 1'b1; fin = 1'b1; extra = 1'b1;
          end
        endcase
      end
      OP_ND: begin
        case (seq_q)
          2'd0: begin
            ph = PH_ADJ; to_t = 1'b1;
          end
          2'd1: begin
            ph = PH_SCALE; src_t = 1'b1;
          end
          default: begin
            ph = PH_FWD; fin = 1'b1; extra = 1'b1; part = 1'b1;
          end
        endcase
      end
      OP_RES: begin
        case (seq_q)
          2'd0: begin
            ph = PH_ADJ; to_t = 1'b1;
          end
          2'd1: begin
            ph = PH_G; diff = 1'b1;
          end
          2'd2: ph = PH_SCALE;
          default: begin
            ph = PH_FWD; fin = 1'b1; part = 1'b1;
          end
        endcase
      end
      OP_DIV: begin
        ph = PH_DIV; fin = 1'b1;
      end
      default: begin
        ph = PH_MUL; fin = 1'b1;
      end
    endcase
  end

  assign olen   = (ph == PH_FWD) ? eff_m : eff_n;
  assign ilen   = (ph == PH_FWD) ? eff_n : eff_m;
  assign e_last = (LW'(elem_q) == olen - LW'(1));
  assign k_last = (LW'(k_q) == ilen - LW'(1));

  assign busy        = (st_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign acc_in      = start && !busy;
  assign ld_mat = acc_in && (action_i == ACT_LOAD_MAT) && (int'(row_i) < MAX_ROWS)
                  && (int'(col_i) < MAX_COLS);
  assign ld_sc  = acc_in && (action_i == ACT_LOAD_SCALE) && (int'(col_i) < MAX_COLS);
  assign ld_x   = acc_in && (action_i == ACT_LOAD_X) && (int'(col_i) < MAX_COLS);
  assign ld_v   = acc_in && (action_i == ACT_LOAD_V) && (int'(row_i) < MAX_ROWS);

  assign mat_we = ld_mat;
  assign xs_we  = ld_sc;
  assign x_we   = ld_x;
  assign v_we   = ld_v;
  assign p_we   = (st_q == S_OUT) && (ph == PH_SCALE);
  assign t_we   = (st_q == S_OUT) && to_t;

  always_comb begin
    if (!busy) begin
      mat_addr = MAW'(int'(row_i) * MAX_COLS + int'(col_i));
      xs_addr  = CAW'(col_i);
      x_addr   = CAW'(col_i);
      v_addr   = RAW'(row_i);
    end else begin
      if (ph == PH_FWD) begin
        mat_addr = MAW'(int'(elem_q) * MAX_COLS + int'(k_q));
      end else begin
        mat_addr = MAW'(int'(k_q) * MAX_COLS + int'(elem_q));
      end
      xs_addr = elem_q[CAW-1:0];
      x_addr  = elem_q[CAW-1:0];
      v_addr  = k_q[RAW-1:0];
    end
    p_addr = p_we ? elem_q[CAW-1:0] : k_q[CAW-1:0];
    if (t_we || ph != PH_ADJ) begin
      t_addr = elem_q;
    end else begin
      t_addr = k_q;
    end
  end

  smvk_ram #(.WIDTH(32), .DEPTH(MDEP)) u_mat (
    .clk_i, .we_i(mat_we), .addr_i(mat_addr), .wdata_i(first_value_i), .rdata_o(mat_rd)
  );
  smvk_ram #(.WIDTH(64), .DEPTH(MAX_COLS)) u_xs (
    .clk_i, .we_i(xs_we), .addr_i(xs_addr), .wdata_i({second_value_i, first_value_i}),
    .rdata_o(xs_rd)
  );
  smvk_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_x (
    .clk_i, .we_i(x_we), .addr_i(x_addr), .wdata_i(first_value_i), .rdata_o(x_rd)
  );
  smvk_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_v (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(first_value_i), .rdata_o(v_rd)
  );
  smvk_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_p (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(res_q), .rdata_o(p_rd)
  );
  smvk_ram #(.WIDTH(33), .DEPTH(VEC_N)) u_t (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i({f_q, res_q}), .rdata_o(t_rd)
  );

  assign xq = xs_vld_r_q ? $signed(xs_rd[31:0]) : Q_ONE;
  assign sq = xs_vld_r_q ? $signed(xs_rd[63:32]) : Q_ONE;

  always_comb begin
    mul_a = xq;
    mul_b = tv_q;
    if (st_q == S_MUL2) begin
      if (ph == PH_G) begin
        mul_a = tv_q;
        mul_b = $signed(x_rd);
      end
    end else begin
      case (ph)
        PH_SCALE: mul_b = src_t ? $signed(t_rd[31:0]) : $signed(x_rd);
        PH_FWD: begin
          mul_a = $signed(mat_rd);
          mul_b = $signed(p_rd);
        end
        PH_ADJ: begin
          mul_a = $signed(mat_rd);
          mul_b = src_t ? $signed(t_rd[31:0]) : $signed(v_rd);
        end
        PH_G: mul_b = sq;
        default: mul_b = $signed(x_rd);
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign sat_a = sat32(acc_q >>> FRAC_BITS);
  assign sat_p = sat32(prod_q >>> FRAC_BITS);
  assign dvec  = $signed({{32{t_rd[31]}}, t_rd[31:0]}) - $signed({{32{res_q[31]}}, res_q});
  assign sat_d = sat32(dvec);
  assign dtry  = {drem_q, dn_q[NW-1]};
  assign qmag  = $signed(64'(dn_q));
  assign sat_q = sat32(dneg_q ? -qmag : qmag);

  always_comb begin
    st_d = st_q; seq_d = seq_q; op_d = op_q; elem_d = elem_q; k_d = k_q;
    acc_d = acc_q; prod_d = prod_q; tv_d = tv_q; res_d = res_q; f_d = f_q;
    fault_d = fault_q; pf_d = pf_q; any_d = any_q;
    dn_d = dn_q; drem_d = drem_q; dd_d = dd_q; dneg_d = dneg_q; dcnt_d = dcnt_q;
    ov_d = 1'b0; oidx_d = oidx_q; oval_d = oval_q; opart_d = opart_q;
    osat_d = osat_q; ofault_d = ofault_q; olast_d = olast_q;
    case (st_q)
      S_IDLE: begin
        if (acc_in && action_i == ACT_RUN) begin
          st_d = S_RD; seq_d = 2'd0; op_d = op_i; elem_d = '0; k_d = '0;
          acc_d = '0; pf_d = 1'b0; any_d = 1'b0; fault_d = 1'b0;
        end
      end
      S_RD: st_d = (ph == PH_DIV) ? S_DSET : S_MUL;
      S_MUL: begin
        prod_d = mul_p;
        st_d = (ph == PH_FWD || ph == PH_ADJ) ? S_ACC : S_SAT;
      end
      S_ACC: begin
        acc_d = acc_q + prod_q;
        if (k_last) begin
          st_d = S_SAT;
        end else begin
          k_d = k_q + IW'(1);
          st_d = S_RD;
        end
      end
      S_SAT: begin
        case (ph)
          PH_FWD: begin
            res_d = sat_a.val; f_d = pf_q | sat_a.clip; acc_d = '0; st_d = S_OUT;
          end
          PH_ADJ: begin
            tv_d = sat_a.val; f_d = sat_a.clip; acc_d = '0; st_d = S_MUL2;
          end
          PH_G: begin
            tv_d = sat_p.val; f_d = sat_p.clip; st_d = S_MUL2;
          end
          default: begin
            res_d = sat_p.val; f_d = sat_p.clip; st_d = S_OUT;
          end
        endcase
      end
      S_MUL2: begin
        prod_d = mul_p;
        st_d = S_SAT2;
      end
      S_SAT2: begin
        res_d = sat_p.val;
        f_d = f_q | sat_p.clip;
        st_d = diff ? S_DIFF : S_OUT;
      end
      S_DIFF: begin
        res_d = sat_d.val;
        f_d = f_q | sat_d.clip | t_rd[32];
        st_d = S_OUT;
      end
      S_DSET: begin
        if (xq == 32'sd0) begin
          res_d = x_rd[31] ? Q_MIN : Q_MAX;
          f_d = 1'b1; fault_d = 1'b1; st_d = S_OUT;
        end else begin
          dn_d = {(x_rd[31] ? (~x_rd + 32'd1) : x_rd), {FRAC_BITS{1'b0}}};
          dd_d = xq[31] ? (~xq + 32'd1) : xq;
          drem_d = '0;
          dneg_d = x_rd[31] ^ xq[31];
          dcnt_d = CW'(NW);
          fault_d = 1'b0;
          st_d = S_DIV;
        end
      end
      S_DIV: begin
        if (dtry >= {1'b0, dd_q}) begin
          drem_d = 32'(dtry - {1'b0, dd_q});
          dn_d = {dn_q[NW-2:0], 1'b1};
        end else begin
          drem_d = dtry[31:0];
          dn_d = {dn_q[NW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - CW'(1);
        if (dcnt_q == CW'(1)) begin
          st_d = S_DFIN;
        end
      end
      S_DFIN: begin
        res_d = sat_q.val;
        f_d = sat_q.clip;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (ph == PH_SCALE) begin
          pf_d = pf_q | f_q;
        end else if (to_t) begin
          any_d = any_q | f_q;
        end else begin
          ov_d = 1'b1;
          oidx_d = 5'(elem_q);
          oval_d = res_q;
          opart_d = part;
          osat_d = f_q | (extra & any_q);
          ofault_d = (ph == PH_DIV) & fault_q;
          olast_d = fin & e_last;
        end
        k_d = '0;
        st_d = S_RD;
        if (e_last) begin
          elem_d = '0;
          if (fin) begin
            st_d = S_IDLE;
          end else begin
            seq_d = seq_q + 2'd1;
            if (ph != PH_SCALE) begin
              pf_d = 1'b0;
            end
          end
        end else begin
          elem_d = elem_q + IW'(1);
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      seq_q <= 2'd0;
      ov_q <= 1'b0;
      rows_q <= 6'(MAX_ROWS);
      cols_q <= 6'(MAX_COLS);
      xs_vld_q <= '0;
      xs_vld_r_q <= 1'b0;
    end else begin
      st_q <= st_d;
      seq_q <= seq_d;
      ov_q <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ROWS) begin
          rows_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_COLS) begin
          cols_q <= cfg_data_i;
        end
      end
      if (xs_we) begin
        xs_vld_q[xs_addr] <= 1'b1;
      end
      xs_vld_r_q <= xs_vld_q[xs_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; elem_q <= elem_d; k_q <= k_d; acc_q <= acc_d; prod_q <= prod_d;
    tv_q <= tv_d; res_q <= res_d; f_q <= f_d; fault_q <= fault_d; pf_q <= pf_d;
    any_q <= any_d; dn_q <= dn_d; drem_q <= drem_d; dd_q <= dd_d; dneg_q <= dneg_d;
    dcnt_q <= dcnt_d; oidx_q <= oidx_d; oval_q <= oval_d; opart_q <= opart_d;
    osat_q <= osat_d; ofault_q <= ofault_d; olast_q <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign out_index_o    = oidx_q;
  assign out_value_o    = oval_q;
  assign out_part_o     = opart_q;
  assign saturated_o    = osat_q;
  assign divide_fault_o = ofault_q;
  assign last_o         = olast_q;

endmodule

[hdl/smvk_checker.sv]
// ----------------------------------------------------------------------------
// smvk_checker
// Port-level checks of the scaled matrix-vector operator, bound to the top.
// ----------------------------------------------------------------------------
module smvk_checker
  import smvk_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [2:0]         action_i,
  input logic               out_valid_o,
  input logic               saturated_o,
  input logic               divide_fault_o,
  input logic               last_o
);

  a_run_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_RUN) |=> busy)
    else $error("run beat did not raise busy");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> busy)
    else $error("non-final result beat while idle");

  a_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (out_valid_o && last_o))
    else $error("busy fell without a last beat");

  a_fault_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_fault_o) |-> saturated_o)
    else $error("divide fault without saturation");

endmodule

bind scaled_matvec_kkt_operator_core smvk_checker u_smvk_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .action_i(action_i),
  .out_valid_o(out_valid_o), .saturated_o(saturated_o),
  .divide_fault_o(divide_fault_o), .last_o(last_o)
);
